### sv/fws_pkg.sv
`timescale 1ns / 1ps
package fws_pkg;

   // register indexes on the csr port
   typedef enum logic [7:0] {
      CSR_TRACK  = 8'd0,
      CSR_BASE   = 8'd1,
      CSR_OFFSET = 8'd2,
      CSR_RADIUS = 8'd3
   } csr_index_type;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 12;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 136;

   localparam int SPEED_W = 18;
   localparam int ANGLE_W = 15;

   // datapath widths
   localparam int XW     = 40;   // cordic x/y, 2^8 scale
   localparam int ZW     = 28;   // angle accumulator, 2^-24 rad
   localparam int DIV_W  = 28;   // offset dividend / quotient
   localparam int REM_W  = 11;
   localparam int DIV_BITS_PER_STEP = 4;
   localparam int DIV_STEPS = DIV_W / DIV_BITS_PER_STEP;
   localparam int MAG_W  = 40;
   localparam int V_W    = 28;
   localparam int Q_W    = 22;

   localparam logic [23:0] GAIN_INV    = 24'd10188014;
   localparam logic [25:0] RECIP_125   = 26'd34359738;   // floor(2^32 / 125)
   localparam logic [39:0] MAG_ROUND   = 40'd256000;
   localparam int          HALF_PI_Q13 = 12868;
   localparam int          SPEED_MAX   = 131071;
   localparam int          SPEED_MIN   = -131072;

   localparam logic [23:0] ATAN_TAB [0:23] = '{
      24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
      24'd1047214,  24'd524117,  24'd262123,  24'd131069,
      24'd65536,    24'd32768,   24'd16384,   24'd8192,
      24'd4096,     24'd2048,    24'd1024,    24'd512,
      24'd256,      24'd128,     24'd64,      24'd32,
      24'd16,       24'd8,       24'd4,       24'd2
   };

   typedef struct packed {
      logic neg;      // lin_speed < 0
      logic off_neg;  // yaw * offset < 0
      logic am_zero;  // A- == 0
      logic b_pos;
      logic b_neg;
   } flag_type;

endpackage

### sv/four_wheel_steer_kinematics.sv
`timescale 1ns / 1ps
// Four-wheel-steer inverse kinematics.
// req channel: one word per body twist command, tdata = lin_speed, yaw_rate.
// rsp channel: one word per command, four wheel speeds and four steer angles.
// csr port: csr_we writes csr_wdata into register csr_addr (track, base,
//    steer offset, radius); unknown indexes are dropped. Write only when idle.
// Throughput: one word per cycle while rsp_tready takes the words. Every stage
//    holds a valid bit and loads whenever it is empty or its content moves on,
//    so bubbles close up and req_tready stays high while any stage is empty.
// Stages: products, sums/abs, CORDIC_STEPS vectoring iterations (two lanes,
//    the offset divider runs 4 bits per stage in the first ones), split gain
//    multiply, gain sum, round /4096, reciprocal multiply for /125, correction
//    and angle, speed sum and saturation.
// Reset: synchronous, clears all valid bits and loads the register defaults
//    (track 500, base 500, offset 0, radius 75).
// Stall: a held rsp word stays stable; upstream keeps filling empty stages,
//    then req_tready drops once the whole pipe is full.
module four_wheel_steer_kinematics #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [15:0] lin_speed, [31:16] yaw_rate
   input  logic [fws_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [17:0] speed_fl, [35:18] speed_fr, [53:36] speed_rl, [71:54] speed_rr,
   // [86:72] angle_fl, [101:87] angle_fr, [116:102] angle_rl,
   // [131:117] angle_rr, [135:132] zero
   output logic [fws_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_we,
   input  logic [fws_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  logic [fws_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fws_pkg::*;

   localparam int S_PRE = 1;
   localparam int S_C0  = 2;
   localparam int S_M0  = S_C0 + CORDIC_STEPS;
   localparam int S_M1  = S_M0 + 1;
   localparam int S_M2  = S_M0 + 2;
   localparam int S_M3  = S_M0 + 3;
   localparam int S_M4  = S_M0 + 4;
   localparam int S_OUT = S_M0 + 5;
   localparam int NSTG  = S_OUT + 1;

   // ---------------- configuration registers
   logic [11:0] track_ff, base_ff;
   logic [9:0]  offset_ff, radius_ff;
   logic [9:0]  divisor;

   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff  <= 12'd500;
         base_ff   <= 12'd500;
         offset_ff <= 10'd0;
         radius_ff <= 10'd75;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_TRACK:  track_ff  <= csr_wdata[11:0];
            CSR_BASE:   base_ff   <= csr_wdata[11:0];
            CSR_OFFSET: offset_ff <= csr_wdata[9:0];
            CSR_RADIUS: radius_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // zero radius divides by one
   assign divisor = (radius_ff == 10'd0) ? 10'd1 : radius_ff;

   // ---------------- valid bits and per-stage load enables
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] en;

   always_comb begin
      en[NSTG-1] = !vld_ff[NSTG-1] || rsp_tready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = vld_ff[NSTG-1];

   // ---------------- stage 0: products
   logic signed [15:0] lin_w, yaw_w;
   logic signed [28:0] tw_in, b_in;
   logic signed [26:0] offp_in;
   logic signed [27:0] l2k_in;
   logic signed [28:0] tw_ff, b_ff;
   logic signed [26:0] offp_ff;
   logic signed [27:0] l2k_ff;
   logic               neg_ff;

   assign lin_w   = $signed(req_tdata[15:0]);
   assign yaw_w   = $signed(req_tdata[31:16]);
   assign tw_in   = yaw_w * $signed({1'b0, track_ff});
   assign b_in    = yaw_w * $signed({1'b0, base_ff});
   assign offp_in = yaw_w * $signed({1'b0, offset_ff});
   assign l2k_in  = lin_w * $signed(12'sd2000);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         tw_ff   <= tw_in;
         b_ff    <= b_in;
         offp_ff <= offp_in;
         l2k_ff  <= l2k_in;
         neg_ff  <= lin_w[15];
      end
   end

   // ---------------- stage 1: A-, A+, abs and CORDIC start values
   logic signed [29:0] am_w, ap_w, amag_w, apmag_w, bs_w;
   logic signed [26:0] offabs_w;
   logic signed [XW-1:0] xa_pre_ff, ya_pre_ff, xb_pre_ff, yb_pre_ff;
   logic [DIV_W-1:0]     dvd_pre_ff;
   flag_type             flag_pre_ff;

   always_comb begin
      am_w     = 30'(l2k_ff) - 30'(tw_ff);
      ap_w     = 30'(l2k_ff) + 30'(tw_ff);
      amag_w   = am_w[29] ? -am_w : am_w;
      apmag_w  = ap_w[29] ? -ap_w : ap_w;
      // denominator sign folded into y
      bs_w     = am_w[29] ? -30'(b_ff) : 30'(b_ff);
      offabs_w = offp_ff[26] ? -offp_ff : offp_ff;
   end

   always_ff @(posedge clock) begin
      if (en[S_PRE]) begin
         xa_pre_ff          <= XW'(amag_w) <<< 8;
         ya_pre_ff          <= XW'(bs_w) <<< 8;
         xb_pre_ff          <= XW'(apmag_w) <<< 8;
         yb_pre_ff          <= XW'(b_ff) <<< 8;
         dvd_pre_ff         <= DIV_W'(offabs_w);
         flag_pre_ff.neg     <= neg_ff;
         flag_pre_ff.off_neg <= offp_ff[26];
         flag_pre_ff.am_zero <= (am_w == 30'sd0);
         flag_pre_ff.b_pos   <= !b_ff[28] && (b_ff != 29'sd0);
         flag_pre_ff.b_neg   <= b_ff[28];
      end
   end

   // ---------------- CORDIC stages, offset divider rides along
   logic signed [XW-1:0] xa_ff [CORDIC_STEPS];
   logic signed [XW-1:0] ya_ff [CORDIC_STEPS];
   logic signed [XW-1:0] xb_ff [CORDIC_STEPS];
   logic signed [XW-1:0] yb_ff [CORDIC_STEPS];
   logic signed [ZW-1:0] za_ff [CORDIC_STEPS];
   logic [DIV_W-1:0]     dvd_ff [CORDIC_STEPS];
   logic [REM_W-1:0]     rem_ff [CORDIC_STEPS];
   flag_type             flag_c_ff [CORDIC_STEPS];

   for (genvar c = 0; c < CORDIC_STEPS; c++) begin : g_cordic
      logic signed [XW-1:0] xa_src, ya_src, xb_src, yb_src;
      logic signed [ZW-1:0] za_src;
      logic [DIV_W-1:0]     dvd_src, dvd_in;
      logic [REM_W-1:0]     rem_src, rem_in;
      flag_type             flag_src;
      logic signed [ZW-1:0] atan_c;

      assign atan_c = ZW'(ATAN_TAB[c]);

      if (c == 0) begin : g_first
         assign xa_src   = xa_pre_ff;
         assign ya_src   = ya_pre_ff;
         assign xb_src   = xb_pre_ff;
         assign yb_src   = yb_pre_ff;
         assign za_src   = '0;
         assign dvd_src  = dvd_pre_ff;
         assign rem_src  = '0;
         assign flag_src = flag_pre_ff;
      end else begin : g_next
         assign xa_src   = xa_ff[c-1];
         assign ya_src   = ya_ff[c-1];
         assign xb_src   = xb_ff[c-1];
         assign yb_src   = yb_ff[c-1];
         assign za_src   = za_ff[c-1];
         assign dvd_src  = dvd_ff[c-1];
         assign rem_src  = rem_ff[c-1];
         assign flag_src = flag_c_ff[c-1];
      end

      if (c < DIV_STEPS) begin : g_div
         // restoring division, quotient bits shift in at the bottom
         always_comb begin
            logic [REM_W-1:0] r;
            logic [DIV_W-1:0] d;
            r = rem_src;
            d = dvd_src;
            for (int j = 0; j < DIV_BITS_PER_STEP; j++) begin
               r = {r[REM_W-2:0], d[DIV_W-1]};
               d = {d[DIV_W-2:0], 1'b0};
               if (r >= {1'b0, divisor}) begin
                  r    = r - {1'b0, divisor};
                  d[0] = 1'b1;
               end
            end
            rem_in = r;
            dvd_in = d;
         end
      end else begin : g_hold
         assign rem_in = rem_src;
         assign dvd_in = dvd_src;
      end

      always_ff @(posedge clock) begin
         if (en[S_C0 + c]) begin
            if (!ya_src[XW-1]) begin
               xa_ff[c] <= xa_src + (ya_src >>> c);
               ya_ff[c] <= ya_src - (xa_src >>> c);
               za_ff[c] <= za_src + atan_c;
            end else begin
               xa_ff[c] <= xa_src - (ya_src >>> c);
               ya_ff[c] <= ya_src + (xa_src >>> c);
               za_ff[c] <= za_src - atan_c;
            end
            if (!yb_src[XW-1]) begin
               xb_ff[c] <= xb_src + (yb_src >>> c);
               yb_ff[c] <= yb_src - (xb_src >>> c);
            end else begin
               xb_ff[c] <= xb_src - (yb_src >>> c);
               yb_ff[c] <= yb_src + (xb_src >>> c);
            end
            dvd_ff[c]    <= dvd_in;
            rem_ff[c]    <= rem_in;
            flag_c_ff[c] <= flag_src;
         end
      end
   end

   // ---------------- M0: gain multiply, split in two partial products
   logic [XW-1:0]  xca_w, xcb_w;
   logic [42:0]    pla_ff, plb_ff;
   logic [44:0]    pha_ff, phb_ff;
   logic signed [ZW-1:0] za_m0_ff, za_m1_ff, za_m2_ff, za_m3_ff;
   logic [DIV_W-1:0] offq_ff [S_M0:S_OUT-1];
   flag_type         flag_m_ff [S_M0:S_OUT-1];

   assign xca_w = xa_ff[CORDIC_STEPS-1][XW-1] ? '0 : xa_ff[CORDIC_STEPS-1];
   assign xcb_w = xb_ff[CORDIC_STEPS-1][XW-1] ? '0 : xb_ff[CORDIC_STEPS-1];

   always_ff @(posedge clock) begin
      if (en[S_M0]) begin
         pla_ff   <= 43'(xca_w[18:0]) * 43'(GAIN_INV);
         pha_ff   <= 45'(xca_w[XW-1:19]) * 45'(GAIN_INV);
         plb_ff   <= 43'(xcb_w[18:0]) * 43'(GAIN_INV);
         phb_ff   <= 45'(xcb_w[XW-1:19]) * 45'(GAIN_INV);
         za_m0_ff <= za_ff[CORDIC_STEPS-1];
      end
   end

   // side data carried through the tail stages
   always_ff @(posedge clock) begin
      if (en[S_M0]) begin
         offq_ff[S_M0]   <= dvd_ff[CORDIC_STEPS-1];
         flag_m_ff[S_M0] <= flag_c_ff[CORDIC_STEPS-1];
      end
      for (int k = S_M0 + 1; k < S_OUT; k++) begin
         if (en[k]) begin
            offq_ff[k]   <= offq_ff[k-1];
            flag_m_ff[k] <= flag_m_ff[k-1];
         end
      end
   end

   // ---------------- M1: gain sum, round at 2^24
   logic [63:0]      suma_w, sumb_w;
   logic [MAG_W-1:0] maga_ff, magb_ff;

   assign suma_w = (64'(pha_ff) << 19) + 64'(pla_ff) + 64'h80_0000;
   assign sumb_w = (64'(phb_ff) << 19) + 64'(plb_ff) + 64'h80_0000;

   always_ff @(posedge clock) begin
      if (en[S_M1]) begin
         maga_ff  <= suma_w[24 +: MAG_W];
         magb_ff  <= sumb_w[24 +: MAG_W];
         za_m1_ff <= za_m0_ff;
      end
   end

   // ---------------- M2: (mag + 256000) >> 12, leaves the divide by 125
   logic [MAG_W-1:0] rnda_w, rndb_w;
   logic [V_W-1:0]   va_ff, vb_ff;

   assign rnda_w = maga_ff + MAG_ROUND;
   assign rndb_w = magb_ff + MAG_ROUND;

   always_ff @(posedge clock) begin
      if (en[S_M2]) begin
         va_ff    <= rnda_w[12 +: V_W];
         vb_ff    <= rndb_w[12 +: V_W];
         za_m2_ff <= za_m1_ff;
      end
   end

   // ---------------- M3: reciprocal multiply, estimate is q or q-1
   logic [53:0]    ema_w, emb_w;
   logic [Q_W-1:0] q0a_ff, q0b_ff;
   logic [V_W-1:0] va_m3_ff, vb_m3_ff;

   assign ema_w = 54'(va_ff) * 54'(RECIP_125);
   assign emb_w = 54'(vb_ff) * 54'(RECIP_125);

   always_ff @(posedge clock) begin
      if (en[S_M3]) begin
         q0a_ff   <= ema_w[32 +: Q_W];
         q0b_ff   <= emb_w[32 +: Q_W];
         va_m3_ff <= va_ff;
         vb_m3_ff <= vb_ff;
         za_m3_ff <= za_m2_ff;
      end
   end

   // ---------------- M4: quotient correction, steering angle
   logic [29:0]    ra_w, rb_w;
   logic [Q_W-1:0] qa_ff, qb_ff;
   logic signed [16:0] angr_w;
   logic signed [ANGLE_W-1:0] ang_w, ang_ff;
   flag_type       fl4_w;

   assign fl4_w  = flag_m_ff[S_M3];
   assign ra_w   = 30'(va_m3_ff) - 30'(q0a_ff) * 30'd125;
   assign rb_w   = 30'(vb_m3_ff) - 30'(q0b_ff) * 30'd125;
   assign angr_w = 17'((za_m3_ff + ZW'(1024)) >>> 11);

   always_comb begin
      if (fl4_w.am_zero) begin
         if (fl4_w.b_pos) begin
            ang_w = ANGLE_W'(HALF_PI_Q13);
         end else if (fl4_w.b_neg) begin
            ang_w = -ANGLE_W'(HALF_PI_Q13);
         end else begin
            ang_w = '0;
         end
      end else if (angr_w > 17'(HALF_PI_Q13)) begin
         ang_w = ANGLE_W'(HALF_PI_Q13);
      end else if (angr_w < -17'(HALF_PI_Q13)) begin
         ang_w = -ANGLE_W'(HALF_PI_Q13);
      end else begin
         ang_w = angr_w[ANGLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_M4]) begin
         qa_ff  <= q0a_ff + Q_W'(ra_w >= 30'd125);
         qb_ff  <= q0b_ff + Q_W'(rb_w >= 30'd125);
         ang_ff <= ang_w;
      end
   end

   // ---------------- output stage: sign, offset term, saturation
   function automatic logic [SPEED_W-1:0] sat_speed(input logic signed [29:0] v);
      if (v > 30'(SPEED_MAX)) begin
         return SPEED_W'(SPEED_MAX);
      end else if (v < 30'(SPEED_MIN)) begin
         return SPEED_W'(SPEED_MIN);
      end
      return v[SPEED_W-1:0];
   endfunction

   flag_type           fl5_w;
   logic signed [29:0] sm_w, sp_w, off_w;
   logic [SPEED_W-1:0] sfl_ff, sfr_ff, srl_ff, srr_ff;
   logic [ANGLE_W-1:0] afl_ff, afr_ff;

   assign fl5_w = flag_m_ff[S_M4];
   assign sm_w  = fl5_w.neg ? -$signed(30'(qa_ff)) : $signed(30'(qa_ff));
   assign sp_w  = fl5_w.neg ? -$signed(30'(qb_ff)) : $signed(30'(qb_ff));
   assign off_w = fl5_w.off_neg ? -$signed(30'(offq_ff[S_M4]))
                                :  $signed(30'(offq_ff[S_M4]));

   always_ff @(posedge clock) begin
      if (en[S_OUT]) begin
         sfl_ff <= sat_speed(sm_w - off_w);
         sfr_ff <= sat_speed(sp_w - off_w);
         srl_ff <= sat_speed(sp_w + off_w);
         srr_ff <= sat_speed(sm_w + off_w);
         afl_ff <= ang_ff;
         afr_ff <= -ang_ff;
      end
   end

   assign rsp_tdata = {4'b0, afr_ff, afl_ff, afr_ff, afl_ff,
                       srr_ff, srl_ff, sfr_ff, sfl_ff};

endmodule

### sv/fws_check.sv
`timescale 1ns / 1ps
module fws_check (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // a held word stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed under stall");

   // empty output register never blocks the input
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled with empty output");

   // right-hand angles mirror the left ones
   a_mirror: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[101:87] == 15'(15'd0 - rsp_tdata[86:72])) &&
                     (rsp_tdata[131:117] == rsp_tdata[101:87]) &&
                     (rsp_tdata[116:102] == rsp_tdata[86:72]))
      else $error("steer angles not mirrored");

endmodule

bind four_wheel_steer_kinematics fws_check u_fws_check (.*);
